@@ hdl/stt_pkg.sv @@
`default_nettype none
package stt_pkg;

  // Default counter widths
  localparam int STT_OFFSET_BITS = 24;
  localparam int STT_LINE_BITS   = 16;

  // Output field widths
  localparam int STT_OFS_FIELD_W  = 24;
  localparam int STT_LINE_FIELD_W = 16;

  // Queue depths between the parts
  localparam int STT_CQ_DEPTH = 2;
  localparam int STT_TQ_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  typedef enum logic [5:0] {
    KIND_EOF = 6'd0, KIND_IDENT, KIND_STRING, KIND_BYTE, KIND_INT, KIND_FLOAT,
    KIND_UNSIGNED, KIND_COMMENT, KIND_ILLEGAL, KIND_ASSIGN, KIND_EQUAL, KIND_NOT,
    KIND_NOTEQUAL, KIND_LT, KIND_LE, KIND_GT, KIND_GE, KIND_AND, KIND_OR,
    KIND_VBAR, KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_PERCENT,
    KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_LBRACKET,
    KIND_RBRACKET, KIND_COMMA, KIND_SEMI, KIND_COLON, KIND_DOT
  } stt_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } stt_in_t;

  typedef struct packed {
    stt_kind_t                    kind;
    logic [STT_OFS_FIELD_W-1:0]   start_offset;
    logic [STT_OFS_FIELD_W-1:0]   end_offset;
    logic [STT_LINE_FIELD_W-1:0]  start_line;
    logic [STT_LINE_FIELD_W-1:0]  start_column;
    logic                         last;
  } stt_out_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       space;
    logic       id_start;
    logic       id_cont;
    logic       digit;
    stt_kind_t  single;
  } stt_cls_t;

endpackage
`default_nettype wire

@@ hdl/stt_fifo.sv @@
`default_nettype none
module stt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push0,
  input  wire logic                         push1,
  input  wire logic [WIDTH-1:0]             din0,
  input  wire logic [WIDTH-1:0]             din1,
  input  wire logic                         pop,
  output logic      [WIDTH-1:0]             dout,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  // Pointer and fill bookkeeping; second write lands after the first
  always_comb begin
    wp1     = ptr_inc(wp_r);
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push0) wp_nxt = push1 ? ptr_inc(wp1) : wp1;
    if (pop) rp_nxt = ptr_inc(rp_r);
    cnt_nxt = cnt_r + CW'(push0) + CW'(push0 & push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push0) mem_r[wp_r] <= din0;
    if (push0 && push1) mem_r[wp1] <= din1;
  end

  assign dout  = mem_r[rp_r];
  assign count = cnt_r;
endmodule
`default_nettype wire

@@ hdl/stt_front.sv @@
`default_nettype none
module stt_front (
  input  wire logic             in_valid,
  input  wire stt_pkg::stt_in_t in_data,
  input  wire logic             cq_full,
  output logic                  in_stall,
  output logic                  push,
  output stt_pkg::stt_cls_t     cls
);
  import stt_pkg::*;

  logic [7:0] c;
  logic       alpha;

  // Byte classification
  always_comb begin
    c            = in_data.ch;
    alpha        = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    cls.ch       = c;
    cls.eof      = in_data.end_mark || (c == 8'h00);
    cls.space    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    cls.digit    = (c >= 8'h30 && c <= 8'h39);
    cls.id_start = alpha || (c == CH_USCORE);
    cls.id_cont  = alpha || cls.digit || (c == CH_USCORE) || (c == CH_APOS);
    case (c)
      8'h2B:   cls.single = KIND_PLUS;
      8'h2D:   cls.single = KIND_MINUS;
      8'h2A:   cls.single = KIND_STAR;
      8'h25:   cls.single = KIND_PERCENT;
      8'h28:   cls.single = KIND_LPAREN;
      8'h29:   cls.single = KIND_RPAREN;
      8'h7B:   cls.single = KIND_LBRACE;
      8'h7D:   cls.single = KIND_RBRACE;
      8'h5B:   cls.single = KIND_LBRACKET;
      8'h5D:   cls.single = KIND_RBRACKET;
      8'h2C:   cls.single = KIND_COMMA;
      8'h3B:   cls.single = KIND_SEMI;
      8'h3A:   cls.single = KIND_COLON;
      CH_DOT:  cls.single = KIND_DOT;
      default: cls.single = KIND_ILLEGAL;
    endcase
  end

  // Transfer into the class queue whenever it has room
  assign in_stall = cq_full;
  assign push     = in_valid && !cq_full;
endmodule
`default_nettype wire

@@ hdl/stt_back.sv @@
`default_nettype none
module stt_back #(
  parameter int OFFSET_BITS = stt_pkg::STT_OFFSET_BITS,
  parameter int LINE_BITS   = stt_pkg::STT_LINE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cls_valid,
  input  wire stt_pkg::stt_cls_t cls,
  input  wire logic              room,
  output logic                   pop,
  output logic                   push0,
  output logic                   push1,
  output stt_pkg::stt_out_t      tok0,
  output stt_pkg::stt_out_t      tok1
);
  import stt_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_STRING, M_STRING_ESC, M_BYTE_OPEN, M_BYTE_ESC,
    M_BYTE_CLOSE, M_NUMBER, M_SLASH, M_COMMENT,
    M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT, M_OP_AMP, M_OP_BAR
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt, trim_r, trim_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, col_r, col_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic                   dot_r, dot_nxt, fin_r, fin_nxt;

  logic [OFFSET_BITS-1:0] cpos;
  logic [LINE_BITS-1:0]   cline, ccol;
  logic                   go, consume, pending, em_a, em_b, eof;
  stt_out_t               tok_a, tok_b;
  logic [7:0]             c;

  function automatic stt_out_t mk_tok(stt_kind_t k, logic [OFFSET_BITS-1:0] s,
                                      logic [OFFSET_BITS-1:0] e,
                                      logic [LINE_BITS-1:0] l,
                                      logic [LINE_BITS-1:0] cl);
    stt_out_t t;
    t.kind         = k;
    t.start_offset = STT_OFS_FIELD_W'(s);
    t.end_offset   = STT_OFS_FIELD_W'(e);
    t.start_line   = STT_LINE_FIELD_W'(l);
    t.start_column = STT_LINE_FIELD_W'(cl);
    t.last         = 1'b0;
    return t;
  endfunction

  // Position after consuming this byte, saturating
  always_comb begin
    cpos  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    cline = line_r;
    ccol  = (col_r == '1) ? col_r : col_r + 1'b1;
    if (cls.ch == CH_NL) begin
      cline = (line_r == '1) ? line_r : line_r + 1'b1;
      ccol  = LINE_BITS'(1);
    end
  end

  // Scanner: finish the open token, then handle the byte between tokens
  always_comb begin
    go         = cls_valid && room;
    c          = cls.ch;
    eof        = cls.eof;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    dot_nxt    = dot_r;
    trim_nxt   = trim_r;
    fin_nxt    = fin_r;
    consume    = 1'b0;
    pending    = 1'b1;
    em_a       = 1'b0;
    em_b       = 1'b0;
    tok_a      = mk_tok(KIND_EOF, tstart_r, pos_r, tline_r, tcol_r);
    tok_b      = mk_tok(KIND_EOF, pos_r, pos_r, line_r, col_r);

    if (go && !fin_r) begin
      case (mode_r)
        M_IDENT: begin
          if (!eof && cls.id_cont) begin
            consume = 1'b1;
          end else begin
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_IDENT, tstart_r, pos_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end
        end
        M_STRING, M_STRING_ESC: begin
          if (eof) begin
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_STRING, tstart_r, pos_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end else begin
            consume = 1'b1;
            if (mode_r == M_STRING_ESC) begin
              mode_nxt = M_STRING;
            end else if (c == CH_QUOTE) begin
              em_a     = 1'b1;
              tok_a    = mk_tok(KIND_STRING, tstart_r, cpos, tline_r, tcol_r);
              mode_nxt = M_IDLE;
            end else if (c == CH_BSLASH) begin
              mode_nxt = M_STRING_ESC;
            end
          end
        end
        M_BYTE_OPEN, M_BYTE_ESC: begin
          if (eof) begin
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_BYTE, tstart_r, pos_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end else begin
            consume  = 1'b1;
            mode_nxt = (mode_r == M_BYTE_OPEN && c == CH_BSLASH) ? M_BYTE_ESC : M_BYTE_CLOSE;
          end
        end
        M_BYTE_CLOSE: begin
          consume  = !eof && (c == CH_APOS);
          em_a     = 1'b1;
          tok_a    = mk_tok(KIND_BYTE, tstart_r, consume ? cpos : pos_r, tline_r, tcol_r);
          mode_nxt = M_IDLE;
        end
        M_NUMBER: begin
          if (!eof && (cls.digit || (c == CH_DOT && !dot_r))) begin
            if (c == CH_DOT) dot_nxt = 1'b1;
            consume = 1'b1;
          end else if (!eof && c == CH_U) begin
            consume  = 1'b1;
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_UNSIGNED, tstart_r, cpos, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end else begin
            em_a     = 1'b1;
            tok_a    = mk_tok(dot_r ? KIND_FLOAT : KIND_INT, tstart_r, pos_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end
        end
        M_SLASH: begin
          if (!eof && c == CH_SLASH) begin
            consume  = 1'b1;
            trim_nxt = cpos;
            mode_nxt = M_COMMENT;
          end else begin
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_SLASH, tstart_r, pos_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (eof || c == CH_NL) begin
            em_a     = 1'b1;
            tok_a    = mk_tok(KIND_COMMENT, tstart_r, trim_r, tline_r, tcol_r);
            mode_nxt = M_IDLE;
          end else begin
            consume = 1'b1;
            if (!cls.space) trim_nxt = cpos;
          end
        end
        M_OP_EQ, M_OP_BANG, M_OP_LT, M_OP_GT, M_OP_AMP, M_OP_BAR: begin
          em_a     = 1'b1;
          mode_nxt = M_IDLE;
          case (mode_r)
            M_OP_EQ: begin
              consume = !eof && (c == CH_EQ);
              tok_a.kind = consume ? KIND_EQUAL : KIND_ASSIGN;
            end
            M_OP_BANG: begin
              consume = !eof && (c == CH_EQ);
              tok_a.kind = consume ? KIND_NOTEQUAL : KIND_NOT;
            end
            M_OP_LT: begin
              consume = !eof && (c == CH_EQ);
              tok_a.kind = consume ? KIND_LE : KIND_LT;
            end
            M_OP_GT: begin
              consume = !eof && (c == CH_EQ);
              tok_a.kind = consume ? KIND_GE : KIND_GT;
            end
            M_OP_AMP: begin
              consume = !eof && (c == CH_AMP);
              tok_a.kind = consume ? KIND_AND : KIND_ILLEGAL;
            end
            default: begin
              consume = !eof && (c == CH_BAR);
              tok_a.kind = consume ? KIND_OR : KIND_VBAR;
            end
          endcase
          tok_a.end_offset = STT_OFS_FIELD_W'(consume ? cpos : pos_r);
        end
        default: mode_nxt = M_IDLE;
      endcase
      pending = !consume;

      // Byte between tokens
      if (pending) begin
        if (eof) begin
          em_b    = 1'b1;
          tok_b   = mk_tok(KIND_EOF, pos_r, pos_r, line_r, col_r);
          fin_nxt = 1'b1;
        end else if (cls.space) begin
          consume = 1'b1;
        end else begin
          consume    = 1'b1;
          tstart_nxt = pos_r;
          tline_nxt  = line_r;
          tcol_nxt   = col_r;
          if (cls.id_start) begin
            mode_nxt = M_IDENT;
          end else if (c == CH_QUOTE) begin
            mode_nxt = M_STRING;
          end else if (c == CH_APOS) begin
            mode_nxt = M_BYTE_OPEN;
          end else if (cls.digit) begin
            mode_nxt = M_NUMBER;
            dot_nxt  = 1'b0;
          end else if (c == CH_SLASH) begin
            mode_nxt = M_SLASH;
          end else if (c == CH_EQ) begin
            mode_nxt = M_OP_EQ;
          end else if (c == CH_BANG) begin
            mode_nxt = M_OP_BANG;
          end else if (c == CH_LT) begin
            mode_nxt = M_OP_LT;
          end else if (c == CH_GT) begin
            mode_nxt = M_OP_GT;
          end else if (c == CH_AMP) begin
            mode_nxt = M_OP_AMP;
          end else if (c == CH_BAR) begin
            mode_nxt = M_OP_BAR;
          end else begin
            em_b     = 1'b1;
            tok_b    = mk_tok(cls.single, pos_r, cpos, line_r, col_r);
            mode_nxt = M_IDLE;
          end
        end
      end
    end

    tok_a.last = !em_b;
    tok_b.last = 1'b1;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= LINE_BITS'(1);
      col_r    <= LINE_BITS'(1);
      tstart_r <= '0;
      tline_r  <= LINE_BITS'(1);
      tcol_r   <= LINE_BITS'(1);
      dot_r    <= 1'b0;
      trim_r   <= '0;
      fin_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      dot_r    <= dot_nxt;
      trim_r   <= trim_nxt;
      fin_r    <= fin_nxt;
      if (consume) begin
        pos_r  <= cpos;
        line_r <= cline;
        col_r  <= ccol;
      end
    end
  end

  // Results into the token queue, first one in slot zero
  assign pop   = go;
  assign push0 = em_a || em_b;
  assign push1 = em_a && em_b;
  assign tok0  = em_a ? tok_a : tok_b;
  assign tok1  = tok_b;
endmodule
`default_nettype wire

@@ hdl/source_text_tokenizer_unit.sv @@
// Source tokenizer: one source byte accepted per cycle while the class queue has room.
// A token is offered on out_valid once the byte that completes it has been transferred
// and has passed through the class queue, then the scanner into the token queue.
// Output: one token per cycle while out_stall is low; a byte giving two tokens puts both
// in the token queue, and the scanner advances only while it has room for two tokens.
// Reset: synchronous rst_n empties both queues; scanner to line 1, column 1, offset 0.
`default_nettype none
module source_text_tokenizer_unit #(
  parameter int OFFSET_BITS = stt_pkg::STT_OFFSET_BITS,
  parameter int LINE_BITS   = stt_pkg::STT_LINE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stt_pkg::stt_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output stt_pkg::stt_out_t      out_data
);
  import stt_pkg::*;

  localparam int CW = $clog2(STT_CQ_DEPTH+1);
  localparam int TW = $clog2(STT_TQ_DEPTH+1);
  localparam int CLS_W = $bits(stt_cls_t);
  localparam int TOK_W = $bits(stt_out_t);

  logic             cq_push, cq_pop, cq_full;
  stt_cls_t         cls_in, cls_out;
  logic [CLS_W-1:0] cq_dout;
  logic [CW-1:0]    cq_count;

  logic             tq_push0, tq_push1, tq_pop, tq_room;
  stt_out_t         tok0, tok1;
  logic [TOK_W-1:0] tq_dout;
  logic [TW-1:0]    tq_count;

  // Front: classify and queue
  stt_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .cq_full  (cq_full),
    .in_stall (in_stall),
    .push     (cq_push),
    .cls      (cls_in)
  );

  assign cq_full = (cq_count == CW'(STT_CQ_DEPTH));

  stt_fifo #(.WIDTH(CLS_W), .DEPTH(STT_CQ_DEPTH)) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (cq_push),
    .push1 (1'b0),
    .din0  (cls_in),
    .din1  (cls_in),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .count (cq_count)
  );

  assign cls_out = cq_dout;
  assign tq_room = (tq_count <= TW'(STT_TQ_DEPTH-2));

  // Back: scanner
  stt_back #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (cq_count != '0),
    .cls       (cls_out),
    .room      (tq_room),
    .pop       (cq_pop),
    .push0     (tq_push0),
    .push1     (tq_push1),
    .tok0      (tok0),
    .tok1      (tok1)
  );

  // Token queue towards the result channel
  stt_fifo #(.WIDTH(TOK_W), .DEPTH(STT_TQ_DEPTH)) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (tq_push0),
    .push1 (tq_push1),
    .din0  (tok0),
    .din1  (tok1),
    .pop   (tq_pop),
    .dout  (tq_dout),
    .count (tq_count)
  );

  assign out_valid = (tq_count != '0);
  assign out_data  = tq_dout;
  assign tq_pop    = out_valid && !out_stall;
endmodule
`default_nettype wire

@@ test/token_stream_checker.sv @@
module token_stream_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  stt_pkg::stt_out_t out_data,
  input  logic              run_done,
  output int                fail_count,
  output int                pending_tokens,
  output int                tokens_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int OB = STT_OFFSET_BITS;
  localparam int LB = STT_LINE_BITS;

  typedef enum logic [3:0] {
    SC_IDLE, SC_WORD, SC_STR, SC_STR_ESC, SC_CHR_OPEN, SC_CHR_ESC, SC_CHR_CLOSE,
    SC_NUM, SC_SLASH, SC_REMARK, SC_OP_EQ, SC_OP_BANG, SC_OP_LT, SC_OP_GT,
    SC_OP_AMP, SC_OP_BAR
  } scan_state_t;

  // Scanner copy
  scan_state_t   scan;
  logic [OB-1:0] src_pos, lex_start, comment_end;
  logic [LB-1:0] cur_line, cur_col, lex_line, lex_col;
  logic          saw_dot;
  logic          src_ended;

  stt_out_t expected_tokens[$];
  int       mismatches = 0;
  int       checked = 0;
  logic     leftovers_done = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] token check: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Counters stick at their ceiling
  function automatic logic [OB-1:0] ofs_bump(logic [OB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LB-1:0] lc_bump(logic [LB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void advance(logic [7:0] c);
    src_pos = ofs_bump(src_pos);
    if (c == CH_NL) begin
      cur_line = lc_bump(cur_line);
      cur_col  = LB'(1);
    end else begin
      cur_col = lc_bump(cur_col);
    end
  endfunction

  function automatic void emit_token(stt_kind_t k, logic [OB-1:0] s, logic [OB-1:0] e,
                                     logic [LB-1:0] l, logic [LB-1:0] c);
    stt_out_t tok;
    tok.kind         = k;
    tok.start_offset = s;
    tok.end_offset   = e;
    tok.start_line   = l;
    tok.start_column = c;
    tok.last         = 1'b0;
    expected_tokens.push_back(tok);
  endfunction

  function automatic void close_token(stt_kind_t k, logic [OB-1:0] e);
    emit_token(k, lex_start, e, lex_line, lex_col);
  endfunction

  function automatic stt_kind_t punct_kind(logic [7:0] c);
    case (c)
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "%":     return KIND_PERCENT;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "[":     return KIND_LBRACKET;
      "]":     return KIND_RBRACKET;
      ",":     return KIND_COMMA;
      ";":     return KIND_SEMI;
      ":":     return KIND_COLON;
      ".":     return KIND_DOT;
      default: return KIND_ILLEGAL;
    endcase
  endfunction

  function automatic void clear_state();
    scan        = SC_IDLE;
    src_pos     = '0;
    lex_start   = '0;
    comment_end = '0;
    cur_line    = LB'(1);
    cur_col     = LB'(1);
    lex_line    = LB'(1);
    lex_col     = LB'(1);
    saw_dot     = 1'b0;
    src_ended   = 1'b0;
  endfunction

  // Byte seen between tokens: skips a blank, opens a token or gives a one-byte one
  function automatic void start_token(logic [7:0] c);
    scan_state_t nxt;
    nxt = SC_IDLE;
    if (is_blank(c)) begin
      advance(c);
      return;
    end
    lex_start = src_pos;
    lex_line  = cur_line;
    lex_col   = cur_col;
    advance(c);
    if (is_letter(c) || c == CH_USCORE) nxt = SC_WORD;
    else if (c == CH_QUOTE) nxt = SC_STR;
    else if (c == CH_APOS) nxt = SC_CHR_OPEN;
    else if (is_num(c)) begin
      nxt = SC_NUM;
      saw_dot = 1'b0;
    end
    else if (c == CH_SLASH) nxt = SC_SLASH;
    else if (c == CH_EQ) nxt = SC_OP_EQ;
    else if (c == CH_BANG) nxt = SC_OP_BANG;
    else if (c == CH_LT) nxt = SC_OP_LT;
    else if (c == CH_GT) nxt = SC_OP_GT;
    else if (c == CH_AMP) nxt = SC_OP_AMP;
    else if (c == CH_BAR) nxt = SC_OP_BAR;
    else close_token(punct_kind(c), src_pos);
    scan = nxt;
  endfunction

  // Works out the tokens that one transferred byte completes
  task automatic tokenize_byte(input stt_in_t item);
    logic [7:0] c;
    logic       eof;
    logic       fresh;
    int         base;
    logic [7:0] pair_ch;
    stt_kind_t  pair_k, lone_k;
    c     = item.ch;
    eof   = item.end_mark || (item.ch == 8'h00);
    fresh = 1'b1;
    base  = expected_tokens.size();
    if (src_ended) return;

    case (scan)
      SC_WORD: begin
        if (!eof && (is_letter(c) || is_num(c) || c == CH_USCORE || c == CH_APOS)) begin
          advance(c);
          fresh = 1'b0;
        end else begin
          close_token(KIND_IDENT, src_pos);
          scan = SC_IDLE;
        end
      end
      SC_STR, SC_STR_ESC: begin
        if (eof) begin
          close_token(KIND_STRING, src_pos);
          scan = SC_IDLE;
        end else begin
          advance(c);
          fresh = 1'b0;
          if (scan == SC_STR_ESC) scan = SC_STR;
          else if (c == CH_QUOTE) begin
            close_token(KIND_STRING, src_pos);
            scan = SC_IDLE;
          end
          else if (c == CH_BSLASH) scan = SC_STR_ESC;
        end
      end
      SC_CHR_OPEN, SC_CHR_ESC: begin
        if (eof) begin
          close_token(KIND_BYTE, src_pos);
          scan = SC_IDLE;
        end else begin
          advance(c);
          fresh = 1'b0;
          scan = (scan == SC_CHR_OPEN && c == CH_BSLASH) ? SC_CHR_ESC : SC_CHR_CLOSE;
        end
      end
      SC_CHR_CLOSE: begin
        if (!eof && c == CH_APOS) begin
          advance(c);
          fresh = 1'b0;
        end
        close_token(KIND_BYTE, src_pos);
        scan = SC_IDLE;
      end
      SC_NUM: begin
        if (!eof && (is_num(c) || (c == CH_DOT && !saw_dot))) begin
          if (c == CH_DOT) saw_dot = 1'b1;
          advance(c);
          fresh = 1'b0;
        end else if (!eof && c == CH_U) begin
          advance(c);
          fresh = 1'b0;
          close_token(KIND_UNSIGNED, src_pos);
          scan = SC_IDLE;
        end else begin
          close_token(saw_dot ? KIND_FLOAT : KIND_INT, src_pos);
          scan = SC_IDLE;
        end
      end
      SC_SLASH: begin
        if (!eof && c == CH_SLASH) begin
          advance(c);
          fresh = 1'b0;
          comment_end = src_pos;
          scan = SC_REMARK;
        end else begin
          close_token(KIND_SLASH, src_pos);
          scan = SC_IDLE;
        end
      end
      SC_REMARK: begin
        // trailing blanks are left out of the comment
        if (eof || c == CH_NL) begin
          close_token(KIND_COMMENT, comment_end);
          scan = SC_IDLE;
        end else begin
          advance(c);
          fresh = 1'b0;
          if (!is_blank(c)) comment_end = src_pos;
        end
      end
      SC_OP_EQ, SC_OP_BANG, SC_OP_LT, SC_OP_GT, SC_OP_AMP, SC_OP_BAR: begin
        case (scan)
          SC_OP_EQ: begin
            pair_ch = CH_EQ;  pair_k = KIND_EQUAL;    lone_k = KIND_ASSIGN;
          end
          SC_OP_BANG: begin
            pair_ch = CH_EQ;  pair_k = KIND_NOTEQUAL; lone_k = KIND_NOT;
          end
          SC_OP_LT: begin
            pair_ch = CH_EQ;  pair_k = KIND_LE;       lone_k = KIND_LT;
          end
          SC_OP_GT: begin
            pair_ch = CH_EQ;  pair_k = KIND_GE;       lone_k = KIND_GT;
          end
          SC_OP_AMP: begin
            pair_ch = CH_AMP; pair_k = KIND_AND;      lone_k = KIND_ILLEGAL;
          end
          default: begin
            pair_ch = CH_BAR; pair_k = KIND_OR;       lone_k = KIND_VBAR;
          end
        endcase
        if (!eof && c == pair_ch) begin
          advance(c);
          fresh = 1'b0;
          close_token(pair_k, src_pos);
        end else begin
          close_token(lone_k, src_pos);
        end
        scan = SC_IDLE;
      end
      default: scan = SC_IDLE;
    endcase

    if (fresh) begin
      if (eof) begin
        emit_token(KIND_EOF, src_pos, src_pos, cur_line, cur_col);
        src_ended = 1'b1;
      end else begin
        start_token(c);
      end
    end

    if (expected_tokens.size() > base)
      expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endtask

  task automatic check_token(input stt_out_t got);
    stt_out_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("token kind %0d at offset %0d with nothing expected",
                                got.kind, got.start_offset));
      return;
    end
    want = expected_tokens.pop_front();
    checked++;
    if (got.kind !== want.kind)
      report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                checked, got.kind, want.kind));
    if (got.start_offset !== want.start_offset)
      report_mismatch($sformatf("token %0d start offset %0d, expected %0d",
                                checked, got.start_offset, want.start_offset));
    if (got.end_offset !== want.end_offset)
      report_mismatch($sformatf("token %0d end offset %0d, expected %0d",
                                checked, got.end_offset, want.end_offset));
    if (got.start_line !== want.start_line)
      report_mismatch($sformatf("token %0d line %0d, expected %0d",
                                checked, got.start_line, want.start_line));
    if (got.start_column !== want.start_column)
      report_mismatch($sformatf("token %0d column %0d, expected %0d",
                                checked, got.start_column, want.start_column));
    if (got.last !== want.last)
      report_mismatch($sformatf("token %0d last flag %0b, expected %0b",
                                checked, got.last, want.last));
  endtask

  // Watch both channels; counts handed back as registered copies
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token(out_data);
      if (in_valid && !in_stall) tokenize_byte(in_data);
      if (run_done && !leftovers_done) begin
        foreach (expected_tokens[i])
          report_mismatch($sformatf("token kind %0d at offset %0d never arrived",
                                    expected_tokens[i].kind,
                                    expected_tokens[i].start_offset));
        leftovers_done = 1'b1;
      end
    end
    pending_tokens <= expected_tokens.size();
    fail_count     <= mismatches;
    tokens_checked <= checked;
  end

endmodule

@@ test/tb_source_text_tokenizer_unit.sv @@
module tb_source_text_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stt_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BURST_BYTES  = 550;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  stt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stt_out_t out_data;
  logic     run_done = 1'b0;

  int fail_count;
  int pending_tokens;
  int tokens_checked;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  source_text_tokenizer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  token_stream_checker u_token_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .run_done       (run_done),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_checked (tokens_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One transfer on the byte channel, with random gaps in front
  task automatic send_item(input stt_in_t item);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    stt_in_t item;
    item.ch       = c;
    item.end_mark = 1'b0;
    send_item(item);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the source back until every predicted token has arrived
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 5))
      0:       return CH_USCORE;
      1:       return CH_APOS;
      2:       return pick_digit();
      3:       return 8'($urandom_range("A", "Z"));
      default: return 8'($urandom_range("a", "z"));
    endcase
  endfunction

  // Printable, but never a quote or backslash
  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(" ", "~"));
    return (c == CH_QUOTE || c == CH_BSLASH) ? "x" : c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return " ";
      1:       return "\t";
      2:       return CH_NL;
      3:       return "\r";
      4:       return 8'h0B;  // vertical tab
      default: return 8'h0C;  // form feed
    endcase
  endfunction

  function automatic string pick_punct();
    case ($urandom_range(0, 26))
      0:       return "==";
      1:       return "=";
      2:       return "!=";
      3:       return "!";
      4:       return "<=";
      5:       return "<";
      6:       return ">=";
      7:       return ">";
      8:       return "&&";
      9:       return "&";
      10:      return "||";
      11:      return "|";
      12:      return "+";
      13:      return "-";
      14:      return "*";
      15:      return "/";
      16:      return "%";
      17:      return "(";
      18:      return ")";
      19:      return "{";
      20:      return "}";
      21:      return "[";
      22:      return "]";
      23:      return ",";
      24:      return ";";
      25:      return ":";
      default: return ".";
    endcase
  endfunction

  // Mostly well-formed lexemes with random content, some noise bytes
  task automatic send_random_token();
    case ($urandom_range(0, 9))
      0, 1: begin
        send_byte($urandom_range(0, 3) == 0 ? CH_USCORE : 8'($urandom_range("a", "z")));
        repeat ($urandom_range(0, 6)) send_byte(pick_word_char());
      end
      2, 3: begin
        repeat ($urandom_range(1, 4)) send_byte(pick_digit());
        if ($urandom_range(0, 1)) begin
          send_byte(CH_DOT);
          repeat ($urandom_range(0, 3)) send_byte(pick_digit());
          if ($urandom_range(0, 5) == 0) begin
            send_byte(CH_DOT);
            send_byte(pick_digit());
          end
        end
        if ($urandom_range(0, 3) == 0) send_byte(CH_U);
      end
      4: begin
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 7))
            0: begin
              send_byte(CH_BSLASH);
              send_byte(8'($urandom_range(1, 255)));
            end
            1:       send_byte(CH_NL);
            default: send_byte(pick_text_char());
          endcase
        end
        send_byte(CH_QUOTE);
      end
      5: begin
        send_byte(CH_APOS);
        if ($urandom_range(0, 3) == 0) begin
          send_byte(CH_BSLASH);
          send_byte(8'($urandom_range(1, 255)));
        end else begin
          send_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 3) != 0) send_byte(CH_APOS);
      end
      6: begin
        send_text("//");
        repeat ($urandom_range(0, 8))
          send_byte($urandom_range(0, 3) == 0 ? "\t" : pick_text_char());
        repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? " " : "\t");
        send_byte(CH_NL);
      end
      7, 8:    send_text(pick_punct());
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
    // separator, sometimes none so that tokens abut
    if ($urandom_range(0, 3) != 0)
      repeat ($urandom_range(1, 2)) send_byte(pick_blank());
  endtask

  initial begin
    stt_in_t item;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender gaps light, receiver stalls heavy
    src_gap_pct    = 26;
    sink_stall_pct = 56;

    // Directed: each token kind but end of file, and the awkward corners
    send_text("Ab_9'z _ ");
    send_text("\"s\\\"t\nu\" ");
    send_text("'c' '\\'' 'q ");
    send_text("0 12 3.5 4.5.6 7u 8.u ");
    send_text("// note \t \n/ /x ");
    send_text("== = != ! <= < >= > && & || | ");
    send_text("+-*%(){}[],;:.");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("@#$`~?\\ ");

    while (bytes_sent < BURST_BYTES / 3) send_random_token();
    wait_for_drain();

    // Phase 2: the other way round
    src_gap_pct    = 56;
    sink_stall_pct = 26;
    while (bytes_sent < 2 * BURST_BYTES / 3) send_random_token();

    // Phase 3: full rate both sides
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    while (bytes_sent < BURST_BYTES) send_random_token();

    // Leave a token open at the end of the source
    case ($urandom_range(0, 3))
      0:       send_text("\"open \\");
      1:       send_text("// tail  ");
      2:       send_text("'");
      default: send_text("tail_word");
    endcase

    // End of source by either form, then bytes that must be ignored
    if ($urandom_range(0, 1)) begin
      item.ch       = 8'($urandom_range(0, 255));
      item.end_mark = 1'b1;
      send_item(item);
    end else begin
      send_byte(8'h00);
    end
    item.ch       = 8'($urandom_range(1, 255));
    item.end_mark = 1'b1;
    send_item(item);
    repeat (5) begin
      item.ch       = 8'($urandom_range(0, 255));
      item.end_mark = 1'($urandom_range(0, 1));
      send_item(item);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Fed %0d source bytes, checked %0d tokens of every kind, with idle and stall",
             bytes_sent, tokens_checked);
    $display("phases, a full drain pause, an open final token and bytes past the end.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/stt_pkg.sv
hdl/stt_fifo.sv
hdl/stt_front.sv
hdl/stt_back.sv
hdl/source_text_tokenizer_unit.sv
test/token_stream_checker.sv
test/tb_source_text_tokenizer_unit.sv
